@@ src/assert_macros.svh @@
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, held off while arst_n is low
`define CHK_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, held off while arst_n is low
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/mse_pkg.sv @@
// Shared constants for the merge sort engine
package mse_pkg;
	localparam int DATA_W    = 32;
	localparam int MAX_ITEMS = 64;
endpackage

@@ src/mse_ram.sv @@
// Generic RAM: one write port, two read ports, registered read data
module mse_ram #(
	parameter int WIDTH = mse_pkg::DATA_W,
	parameter int DEPTH = mse_pkg::MAX_ITEMS,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr0,
	input  logic [AW-1:0]    raddr1,
	output logic [WIDTH-1:0] rdata0,
	output logic [WIDTH-1:0] rdata1
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end
endmodule

@@ src/merge_sort_engine_unit.sv @@
// Items load one per cycle while idle; after the final item, sorting takes
// P = ceil(log2 n) merge passes, each a prime state then the merge state, then output.
// Merging is bound by one word written to the ping-pong store per cycle; a new list
// is taken only when idle. Results come one per cycle and cannot be stalled.
// Reset clears control and the item count; the two stores keep their contents.
module merge_sort_engine_unit #(
	parameter int MAX_ITEMS = mse_pkg::MAX_ITEMS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [mse_pkg::DATA_W-1:0]  value,
	input  logic                               last,
	output logic                               strobe,
	output logic signed [mse_pkg::DATA_W-1:0]  value_res,
	output logic                               last_res
);
	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = AW + 1;
	localparam int XW = CW + 1;
	localparam int DW = mse_pkg::DATA_W;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_PRIME = 4'b0010,
		S_MERGE = 4'b0100,
		S_DRAIN = 4'b1000
	} state_t;

	state_t         state_q;
	logic [CW-1:0]  count_q, n_q, width_q, mid_q, hi_q, i_q, j_q, k_q, o_q;
	logic           sel_q, strobe_q, last_q;

	logic [DW-1:0]  rda0, rda1, rdb0, rdb1, src_i, src_j, wr_val;
	logic           accept, end_in, take_i, run_done, pass_done, sort_done;
	logic [CW-1:0]  n_in, i_n, j_n, k_n, width2, nb, lo_b, w_b, mid_b, hi_b;
	logic [XW-1:0]  mid_x, hi_x;
	logic [AW-1:0]  raddr0, raddr1;
	logic           we_a, we_b;
	logic [AW-1:0]  waddr_a;
	logic [DW-1:0]  wdata_a;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign n_in   = count_q + CW'(1);
	assign end_in = last || (n_in == CW'(MAX_ITEMS));

	// sel_q set: store b holds the current source run
	assign src_i  = sel_q ? rdb0 : rda0;
	assign src_j  = sel_q ? rdb1 : rda1;

	assign take_i = (i_q < mid_q) &&
	                ((j_q >= hi_q) || ($signed(src_i) <= $signed(src_j)));
	assign wr_val = take_i ? src_i : src_j;
	assign i_n    = i_q + CW'(take_i);
	assign j_n    = j_q + CW'(!take_i);
	assign k_n    = k_q + CW'(1);
	assign width2 = width_q << 1;

	assign run_done  = (k_n == hi_q);
	assign pass_done = run_done && (hi_q == n_q);
	assign sort_done = pass_done && (width2 >= n_q);

	// Bounds of the next run: start of list on a new pass, else after this run
	always_comb begin
		if (state_q == S_IDLE) begin
			nb   = n_in;
			lo_b = '0;
			w_b  = CW'(1);
		end else if (pass_done) begin
			nb   = n_q;
			lo_b = '0;
			w_b  = width2;
		end else begin
			nb   = n_q;
			lo_b = hi_q;
			w_b  = width_q;
		end
		mid_x = XW'(lo_b) + XW'(w_b);
		hi_x  = mid_x + XW'(w_b);
		mid_b = (mid_x > XW'(nb)) ? nb : mid_x[CW-1:0];
		hi_b  = (hi_x > XW'(nb)) ? nb : hi_x[CW-1:0];
	end

	// Issue reads for the heads needed in the next cycle
	always_comb begin
		case (state_q)
			S_MERGE: begin
				if (run_done) begin
					raddr0 = lo_b[AW-1:0];
					raddr1 = mid_b[AW-1:0];
				end else begin
					raddr0 = i_n[AW-1:0];
					raddr1 = j_n[AW-1:0];
				end
			end
			S_DRAIN: begin
				raddr0 = o_q[AW-1:0];
				raddr1 = j_q[AW-1:0];
			end
			default: begin
				raddr0 = i_q[AW-1:0];
				raddr1 = j_q[AW-1:0];
			end
		endcase
	end

	assign we_a    = accept || ((state_q == S_MERGE) && sel_q);
	assign we_b    = (state_q == S_MERGE) && !sel_q;
	assign waddr_a = (state_q == S_MERGE) ? k_q[AW-1:0] : count_q[AW-1:0];
	assign wdata_a = (state_q == S_MERGE) ? wr_val : value;

	mse_ram #(.WIDTH(DW), .DEPTH(MAX_ITEMS)) u_store_a (
		.clk    (clk),
		.we     (we_a),
		.waddr  (waddr_a),
		.wdata  (wdata_a),
		.raddr0 (raddr0),
		.raddr1 (raddr1),
		.rdata0 (rda0),
		.rdata1 (rda1)
	);

	mse_ram #(.WIDTH(DW), .DEPTH(MAX_ITEMS)) u_store_b (
		.clk    (clk),
		.we     (we_b),
		.waddr  (k_q[AW-1:0]),
		.wdata  (wr_val),
		.raddr0 (raddr0),
		.raddr1 (raddr1),
		.rdata0 (rdb0),
		.rdata1 (rdb1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			n_q      <= '0;
			width_q  <= '0;
			mid_q    <= '0;
			hi_q     <= '0;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			o_q      <= '0;
			sel_q    <= 1'b0;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						count_q <= end_in ? '0 : n_in;
						if (end_in) begin
							n_q   <= n_in;
							sel_q <= 1'b0;
							if (n_in == CW'(1)) begin
								o_q     <= '0;
								state_q <= S_DRAIN;
							end else begin
								width_q <= CW'(1);
								mid_q   <= mid_b;
								hi_q    <= hi_b;
								i_q     <= '0;
								j_q     <= mid_b;
								k_q     <= '0;
								state_q <= S_PRIME;
							end
						end
					end
				end
				S_PRIME: begin
					state_q <= S_MERGE;
				end
				S_MERGE: begin
					i_q <= i_n;
					j_q <= j_n;
					k_q <= k_n;
					if (sort_done) begin
						sel_q   <= !sel_q;
						o_q     <= '0;
						state_q <= S_DRAIN;
					end else if (pass_done) begin
						// pass through the prime state so the first reads see the last write of the pass
						sel_q   <= !sel_q;
						width_q <= width2;
						mid_q   <= mid_b;
						hi_q    <= hi_b;
						i_q     <= '0;
						j_q     <= mid_b;
						k_q     <= '0;
						state_q <= S_PRIME;
					end else if (run_done) begin
						mid_q <= mid_b;
						hi_q  <= hi_b;
						i_q   <= hi_q;
						j_q   <= mid_b;
					end
				end
				S_DRAIN: begin
					strobe_q <= 1'b1;
					last_q   <= (o_q == n_q - CW'(1));
					o_q      <= o_q + CW'(1);
					if (o_q == n_q - CW'(1)) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign strobe    = strobe_q;
	assign last_res  = last_q;
	assign value_res = src_i;
endmodule

@@ src/mse_checker.sv @@
// Port-level checker for the merge sort engine, bound to the top level
`include "assert_macros.svh"

module mse_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic strobe,
	input logic last_res
);
	// an accepted item never shares the next cycle with a result
	`CHK_NEXT(a_accept_quiet, start && !busy, !strobe, "result right after an accepted item")
	// a sorted list leaves as one unbroken burst
	`CHK_NEXT(a_burst_contig, strobe && !last_res, strobe, "gap inside a result burst")
	// only the final result may appear once the block has gone idle
	`CHK_SAME(a_idle_final, strobe && !busy, last_res, "non-final result while idle")
	// a burst ends before the next one can start
	`CHK_NEXT(a_last_ends, strobe && last_res, !strobe, "result after the final one")
endmodule

bind merge_sort_engine_unit mse_checker u_mse_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.strobe   (strobe),
	.last_res (last_res)
);
